// File: rtl/vario_tone_selector_unit_macros.svh
// Assertion macros shared by the vario tone selector RTL.
`ifndef VARIO_TONE_SELECTOR_UNIT_MACROS_SVH
`define VARIO_TONE_SELECTOR_UNIT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define VTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vario tone selector: implication check failed");

// Next-cycle implication, held off while reset is asserted.
`define VTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vario tone selector: next-cycle check failed");

`endif

// File: rtl/vts_pkg.sv
// Types, codes and tone tables of the vario tone selector.
`timescale 1ns / 1ps

package vts_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INDEX,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } vts_state_t;

    // Tone modes as they appear on the output.
    typedef enum logic [1:0] {
        TONE_SILENT = 2'd0,
        TONE_SINK   = 2'd1,
        TONE_CLIMB  = 2'd2
    } tone_mode_t;

    // Operations run one after another on the shared multiply/divide unit.
    typedef enum logic [2:0] {
        OP_FREQ,
        OP_PERIOD,
        OP_DUTY,
        OP_SCALE,
        OP_ON
    } vts_op_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SINK  = 2'd0;
    localparam logic [1:0] CFG_CLIMB = 2'd1;
    localparam logic [1:0] CFG_HYST  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic signed [11:0] SINK_RESET  = -12'sd300;
    localparam logic signed [11:0] CLIMB_RESET = 12'sd20;
    localparam logic [8:0]         HYST_RESET  = 9'd10;

    // Table size and the fixed factors of the period and on-time steps.
    localparam logic [3:0] TONE_COUNT = 4'd12;
    localparam logic [3:0] TONE_LAST  = 4'd11;
    localparam logic [9:0] SCALE_NUM  = 10'd3;
    localparam logic [9:0] SCALE_DEN  = 10'd5;
    localparam logic [9:0] PERCENT    = 10'd100;

    function automatic logic signed [11:0] tone_speed(input logic [3:0] k);
        logic signed [11:0] r;
        case (k)
            4'd0:    r = -12'sd1000;
            4'd1:    r = -12'sd300;
            4'd2:    r = -12'sd51;
            4'd3:    r = -12'sd50;
            4'd4:    r = 12'sd9;
            4'd5:    r = 12'sd10;
            4'd6:    r = 12'sd116;
            4'd7:    r = 12'sd267;
            4'd8:    r = 12'sd424;
            4'd9:    r = 12'sd600;
            4'd10:   r = 12'sd800;
            4'd11:   r = 12'sd1000;
            default: r = 12'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [11:0] tone_freq(input logic [3:0] k);
        logic signed [11:0] r;
        case (k)
            4'd0:    r = 12'sd200;
            4'd1:    r = 12'sd280;
            4'd2:    r = 12'sd300;
            4'd3:    r = 12'sd200;
            4'd4:    r = 12'sd400;
            4'd5:    r = 12'sd400;
            4'd6:    r = 12'sd550;
            4'd7:    r = 12'sd763;
            4'd8:    r = 12'sd985;
            4'd9:    r = 12'sd1234;
            4'd10:   r = 12'sd1517;
            4'd11:   r = 12'sd1800;
            default: r = 12'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [11:0] tone_period(input logic [3:0] k);
        logic signed [11:0] r;
        case (k)
            4'd0:    r = 12'sd100;
            4'd1:    r = 12'sd100;
            4'd2:    r = 12'sd500;
            4'd3:    r = 12'sd800;
            4'd4:    r = 12'sd600;
            4'd5:    r = 12'sd600;
            4'd6:    r = 12'sd552;
            4'd7:    r = 12'sd483;
            4'd8:    r = 12'sd412;
            4'd9:    r = 12'sd322;
            4'd10:   r = 12'sd241;
            4'd11:   r = 12'sd150;
            default: r = 12'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [11:0] tone_duty(input logic [3:0] k);
        logic signed [11:0] r;
        case (k)
            4'd0:    r = 12'sd100;
            4'd1:    r = 12'sd100;
            4'd2:    r = 12'sd100;
            4'd3:    r = 12'sd5;
            4'd4:    r = 12'sd10;
            4'd5:    r = 12'sd50;
            4'd6:    r = 12'sd52;
            4'd7:    r = 12'sd55;
            4'd8:    r = 12'sd58;
            4'd9:    r = 12'sd62;
            4'd10:   r = 12'sd66;
            4'd11:   r = 12'sd70;
            default: r = 12'sd0;
        endcase
        return r;
    endfunction

    // Picks the table that an interpolation operation works on.
    function automatic logic signed [11:0] tone_value(input vts_op_t op, input logic [3:0] k);
        logic signed [11:0] r;
        case (op)
            OP_FREQ:   r = tone_freq(k);
            OP_PERIOD: r = tone_period(k);
            OP_DUTY:   r = tone_duty(k);
            default:   r = 12'sd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/vario_tone_selector_unit.sv
// Vario tone selector: hysteresis mode tracking and bit-serial tone interpolation.
//
// Usage: one vertical speed sample (speed_cms, signed cm/s) enters as a beat on the
// speed channel (speed_valid/speed_ready); one tone beat leaves on the tone channel
// (tone_valid/tone_ready) carrying tone_mode, freq_hz, period_ms and on_ms.
// Thresholds and hysteresis are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle (not enforced); index 3 writes are ignored.
//
// Timing: a sample that leaves the block silent goes straight to the final step, and the
// next sample is taken once its tone beat is in the output register. A sinking or climbing
// sample runs five operations (frequency, period and duty interpolation, then the 3/5
// period scale and the on-time percentage) through one shared shift-and-add multiplier
// and restoring divider, each as a load step, a multiply step per multiplier bit, a
// quotient step per quotient bit and a finish step. No new sample is taken until that
// sample's tone beat is loaded, so the shared unit sets the throughput.
//
// Reset: rst_n is asynchronous and active low. It restores the default thresholds
// (-300, 20) and hysteresis (10), sets the mode to silent and empties the output.
// Stall: the finished beat waits in an output register while the next sample is taken
// and worked on; the block then holds in its final step until the register is free.
`timescale 1ns / 1ps
`include "vario_tone_selector_unit_macros.svh"

module vario_tone_selector_unit
    import vts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               speed_valid,
    output logic               speed_ready,
    input  logic signed [15:0] speed_cms,
    output logic               tone_valid,
    input  logic               tone_ready,
    output logic [1:0]         tone_mode,
    output logic [10:0]        freq_hz,
    output logic [8:0]         period_ms,
    output logic [8:0]         on_ms
);

    // Bits handled by the multiplier operand and by the quotient.
    localparam int OpW   = 10;
    localparam int ProdW = 2 * OpW;
    localparam logic [3:0] BitLast = 4'(OpW - 1);

    // Control state.
    vts_state_t        state_reg, state_next;
    tone_mode_t        mode_reg, mode_next;
    vts_op_t           op_reg, op_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic signed [11:0] sink_reg, sink_next;
    logic signed [11:0] climb_reg, climb_next;
    logic [8:0]        hyst_reg, hyst_next;
    logic              out_valid_reg, out_valid_next;

    // Datapath state.
    logic signed [15:0] v_reg, v_next;
    logic [3:0]        idx_reg, idx_next;
    logic [ProdW-1:0]  mcand_reg, mcand_next;
    logic [OpW-1:0]    mplier_reg, mplier_next;
    logic [ProdW-1:0]  acc_reg, acc_next;
    logic [OpW-1:0]    div_reg, div_next;
    logic [OpW-1:0]    rem_reg, rem_next;
    logic [OpW-1:0]    quo_reg, quo_next;
    logic              neg_reg, neg_next;
    logic [10:0]       base_reg, base_next;
    logic [10:0]       freq_reg, freq_next;
    logic [9:0]        per_reg, per_next;
    logic [8:0]        duty_reg, duty_next;
    tone_mode_t        out_mode_reg, out_mode_next;
    logic [10:0]       out_freq_reg, out_freq_next;
    logic [8:0]        out_per_reg, out_per_next;
    logic [8:0]        out_on_reg, out_on_next;

    // Sequencer outputs.
    logic              take_speed;
    logic              out_load;

    // Mode update on the incoming sample.
    logic signed [17:0] v_ext, sink_ext, climb_ext, hyst_ext;
    logic              le_sink, ge_climb, change;
    tone_mode_t        mode_cand, mode_upd;

    always_comb
    begin
        v_ext     = {{2{speed_cms[15]}}, speed_cms};
        sink_ext  = {{6{sink_reg[11]}}, sink_reg};
        climb_ext = {{6{climb_reg[11]}}, climb_reg};
        hyst_ext  = {9'd0, hyst_reg};
        le_sink   = (v_ext <= sink_ext);
        ge_climb  = (v_ext >= climb_ext);
        case (mode_reg)
            TONE_SINK:  change = (v_ext > (sink_ext + hyst_ext));
            TONE_CLIMB: change = (v_ext < (climb_ext - hyst_ext));
            default:    change = le_sink || ge_climb;
        endcase
        if (le_sink)
            mode_cand = TONE_SINK;
        else if (ge_climb)
            mode_cand = TONE_CLIMB;
        else
            mode_cand = TONE_SILENT;
        mode_upd = change ? mode_cand : mode_reg;
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (speed_valid)
                    state_next = (mode_upd == TONE_SINK || mode_upd == TONE_CLIMB)
                                 ? ST_INDEX : ST_DONE;
            end
            ST_INDEX: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_MUL;
            ST_MUL:
            begin
                if (cnt_reg == BitLast)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == BitLast)
                    state_next = ST_FIN;
            end
            ST_FIN:   state_next = (op_reg == OP_ON) ? ST_DONE : ST_LOAD;
            ST_DONE:
            begin
                if (!out_valid_reg || tone_ready)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        speed_ready = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: speed_ready = 1'b1;
            ST_DONE: out_load    = !out_valid_reg || tone_ready;
            default:
            begin
                speed_ready = 1'b0;
                out_load    = 1'b0;
            end
        endcase
        take_speed = speed_ready && speed_valid;
    end

    // Operand selection for the next operation.
    logic              clamp;
    logic [3:0]        k_lo, k_clamp, idx_find;
    logic signed [11:0] t_hi, t_lo;
    logic signed [12:0] dy, dy_abs, ds;
    logic signed [16:0] dx;

    always_comb
    begin
        clamp   = (idx_reg == 4'd0) || (idx_reg == TONE_COUNT);
        k_lo    = idx_reg - 4'd1;
        k_clamp = (idx_reg == TONE_COUNT) ? TONE_LAST : idx_reg;
        t_hi    = tone_value(op_reg, idx_reg);
        t_lo    = tone_value(op_reg, clamp ? k_clamp : k_lo);
        dy      = 13'(t_hi) - 13'(t_lo);
        dy_abs  = dy[12] ? -dy : dy;
        ds      = 13'(tone_speed(idx_reg)) - 13'(tone_speed(k_lo));
        dx      = 17'(v_reg) - 17'(tone_speed(k_lo));
    end

    // First table entry at or above the sample; 12 when above the table.
    always_comb
    begin
        idx_find = TONE_COUNT;
        for (int k = int'(TONE_LAST); k >= 0; k--)
        begin
            if (v_reg <= 16'(tone_speed(4'(k))))
                idx_find = 4'(k);
        end
    end

    // Serial multiply, divide and finish arithmetic.
    logic [ProdW-1:0]  acc_sum;
    logic [OpW:0]      trial;
    logic              trial_ge;
    logic signed [11:0] q_pos, q_sgn, res;

    always_comb
    begin
        acc_sum  = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
        trial    = {rem_reg, quo_reg[OpW-1]};
        trial_ge = (trial >= {1'b0, div_reg});
        q_pos    = 12'(quo_reg);
        // Floor of a negative quotient: -q when exact, otherwise -q - 1 (which is ~q).
        q_sgn    = neg_reg ? (~q_pos + 12'(rem_reg == '0)) : q_pos;
        res      = q_sgn + 12'(base_reg);
    end

    // Next values of all registers.
    always_comb
    begin
        mode_next      = mode_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        sink_next      = sink_reg;
        climb_next     = climb_reg;
        hyst_next      = hyst_reg;
        out_valid_next = out_valid_reg;
        v_next         = v_reg;
        idx_next       = idx_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        base_next      = base_reg;
        freq_next      = freq_reg;
        per_next       = per_reg;
        duty_next      = duty_reg;
        out_mode_next  = out_mode_reg;
        out_freq_next  = out_freq_reg;
        out_per_next   = out_per_reg;
        out_on_next    = out_on_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SINK:  sink_next  = cfg_data;
                CFG_CLIMB: climb_next = cfg_data;
                CFG_HYST:  hyst_next  = cfg_data[8:0];
                default:   sink_next  = sink_reg;
            endcase
        end

        if (tone_valid && tone_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (take_speed)
                begin
                    v_next    = speed_cms;
                    mode_next = mode_upd;
                    op_next   = OP_FREQ;
                    freq_next = '0;
                    per_next  = '0;
                    duty_next = '0;
                end
            end
            ST_INDEX:
            begin
                idx_next = idx_find;
            end
            ST_LOAD:
            begin
                cnt_next = '0;
                acc_next = '0;
                case (op_reg)
                    OP_SCALE:
                    begin
                        mcand_next  = ProdW'(per_reg);
                        mplier_next = SCALE_NUM;
                        div_next    = SCALE_DEN;
                        neg_next    = 1'b0;
                        base_next   = '0;
                    end
                    OP_ON:
                    begin
                        mcand_next  = ProdW'(per_reg);
                        mplier_next = OpW'(duty_reg);
                        div_next    = PERCENT;
                        neg_next    = 1'b0;
                        base_next   = '0;
                    end
                    default:
                    begin
                        if (clamp)
                        begin
                            // Outside the table: take the end entry unchanged.
                            mcand_next  = '0;
                            mplier_next = '0;
                            div_next    = OpW'(1);
                            neg_next    = 1'b0;
                        end
                        else
                        begin
                            mcand_next  = ProdW'(dy_abs[OpW-1:0]);
                            mplier_next = dx[OpW-1:0];
                            div_next    = ds[OpW-1:0];
                            neg_next    = dy[12];
                        end
                        base_next = t_lo[10:0];
                    end
                endcase
            end
            ST_MUL:
            begin
                acc_next    = acc_sum;
                mcand_next  = {mcand_reg[ProdW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[OpW-1:1]};
                cnt_next    = cnt_reg + 4'd1;
                if (cnt_reg == BitLast)
                begin
                    cnt_next = '0;
                    // The quotient fits in OpW bits, so the upper half is below the divisor.
                    rem_next = acc_sum[ProdW-1:OpW];
                    quo_next = acc_sum[OpW-1:0];
                end
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? OpW'(trial - {1'b0, div_reg}) : trial[OpW-1:0];
                quo_next = {quo_reg[OpW-2:0], trial_ge};
                cnt_next = cnt_reg + 4'd1;
            end
            ST_FIN:
            begin
                case (op_reg)
                    OP_FREQ:   freq_next = res[10:0];
                    OP_PERIOD: per_next  = res[9:0];
                    OP_DUTY:   duty_next = res[8:0];
                    OP_SCALE:  per_next  = res[9:0];
                    default:   duty_next = res[8:0];
                endcase
                if (op_reg != OP_ON)
                    op_next = vts_op_t'(op_reg + 3'd1);
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_mode_next  = mode_reg;
                    out_freq_next  = freq_reg;
                    // Equal period and on-time mean a continuous tone.
                    if (per_reg == 10'(duty_reg))
                    begin
                        out_per_next = '0;
                        out_on_next  = '0;
                    end
                    else
                    begin
                        out_per_next = per_reg[8:0];
                        out_on_next  = duty_reg;
                    end
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= TONE_SILENT;
            op_reg        <= OP_FREQ;
            cnt_reg       <= '0;
            sink_reg      <= SINK_RESET;
            climb_reg     <= CLIMB_RESET;
            hyst_reg      <= HYST_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            sink_reg      <= sink_next;
            climb_reg     <= climb_next;
            hyst_reg      <= hyst_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        idx_reg      <= idx_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        acc_reg      <= acc_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        neg_reg      <= neg_next;
        base_reg     <= base_next;
        freq_reg     <= freq_next;
        per_reg      <= per_next;
        duty_reg     <= duty_next;
        out_mode_reg <= out_mode_next;
        out_freq_reg <= out_freq_next;
        out_per_reg  <= out_per_next;
        out_on_reg   <= out_on_next;
    end

    assign tone_valid = out_valid_reg;
    assign tone_mode  = out_mode_reg;
    assign freq_hz    = out_freq_reg;
    assign period_ms  = out_per_reg;
    assign on_ms      = out_on_reg;

    // A silent beat carries no tone.
    `VTS_ASSERT_IMPLY(a_silent_mute, clk, rst_n,
        tone_valid && (tone_mode == TONE_SILENT),
        (freq_hz == 11'd0) && (period_ms == 9'd0) && (on_ms == 9'd0))
    // Once a sample is taken the block is busy with it.
    `VTS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, speed_valid && speed_ready, !speed_ready)
    // The partial remainder always stays below the divisor.
    `VTS_ASSERT_IMPLY(a_rem_below_div, clk, rst_n, state_reg == ST_DIV, rem_reg < div_reg)
    // Equal period and on-time never leave the block; they collapse to zero.
    `VTS_ASSERT_IMPLY(a_continuous_zero, clk, rst_n, tone_valid,
        (period_ms != on_ms) || (period_ms == 9'd0))

endmodule
